FILE: hw/rtl/isort_pkg.sv
package isort_pkg;

  localparam int unsigned ValueW = 32;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] sorted_value;
    logic                     end_of_run;
    logic                     overflow;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/isort_cell.sv
module isort_cell import isort_pkg::*; (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [ValueW-1:0] ins_val_i,
  input  logic                     occ_i,
  input  logic                     prev_occ_i,
  input  logic                     prev_gt_i,
  input  logic signed [ValueW-1:0] prev_val_i,
  input  logic signed [ValueW-1:0] next_val_i,
  output logic signed [ValueW-1:0] val_o,
  output logic                     gt_o
);

  logic signed [ValueW-1:0] val_q, val_d;
  logic                     take;

  assign gt_o  = occ_i && (val_q > ins_val_i);
  assign take  = gt_o || (!occ_i && prev_occ_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins && take) begin
      val_d = prev_gt_i ? prev_val_i : ins_val_i;
    end else if (ctrl_i.shift) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: hw/rtl/insertion_sorter_core.sv
// Stable insertion sorter built as a row of DEPTH cells. While a set is being
// collected the block takes one item per cycle: the new value is broadcast to
// every cell, each cell compares it with its own value, and larger values step
// up one cell in the same cycle. An item marked last is inserted and then the
// set drains from the bottom cell into the output register, one result per
// cycle while the output is not stalled. The drain flag is registered when
// the last item is accepted, and each result is registered in the output
// register before it is presented. Input stall is held high during that
// drain. Values arriving while all DEPTH cells are full are dropped, and
// every result of that run carries the overflow flag.
module insertion_sorter_core import isort_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]          count_q, count_d;
  logic                     drain_q, drain_d;
  logic                     dropped_q, dropped_d;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_q, out_d;
  logic                     in_acc, full, step;
  cell_ctrl_t               ctrl;
  logic [DEPTH-1:0]         occ, gt;
  logic signed [ValueW-1:0] vals [DEPTH];

  assign in_acc = in_valid_i && !in_stall_o;
  assign full   = count_q == CntW'(DEPTH);
  assign step   = drain_q && (!out_valid_q || !out_stall_i);

  assign ctrl.ins   = in_acc && !full;
  assign ctrl.shift = step;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = count_q > CntW'(i);
    isort_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .ins_val_i  (in_item_i.value),
      .occ_i      (occ[i]),
      .prev_occ_i ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i-1]),
      .prev_gt_i  ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .prev_val_i (vals[(i == 0) ? 0 : i-1]),
      .next_val_i (vals[(i == DEPTH-1) ? i : i+1]),
      .val_o      (vals[i]),
      .gt_o       (gt[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    drain_d     = drain_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (in_acc) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
      if (in_item_i.last) begin
        drain_d = 1'b1;
      end
    end
    if (step) begin
      out_valid_d         = 1'b1;
      out_d.sorted_value  = vals[0];
      out_d.end_of_run    = count_q == CntW'(1);
      out_d.overflow      = dropped_q;
      count_d             = count_q - CntW'(1);
      if (count_q == CntW'(1)) begin
        drain_d   = 1'b0;
        dropped_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drain_q     <= 1'b0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drain_q     <= drain_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = drain_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import isort_pkg::*;

  localparam int unsigned DEPTH = 16;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      tx_valid = 1'b0;
  in_item_t  tx_item = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  logic signed [ValueW-1:0] sort_store [DEPTH];
  int unsigned              store_fill = 0;
  logic                     store_dropped = 1'b0;
  out_item_t                sorted_expect [$];

  int unsigned items_sent = 0;
  int unsigned err_count = 0;
  int unsigned gap_pct = 25;
  int unsigned stall_pct = 25;
  bit          hold_req = 1'b0;
  int unsigned hold_len = 0;

  insertion_sorter_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (tx_valid),
    .in_stall_o (in_stall),
    .in_item_i  (tx_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // insert stably: the new value lands above every equal stored value
  task automatic sort_insert(input logic signed [ValueW-1:0] v);
    int unsigned pos;
    if (store_fill >= DEPTH) begin
      store_dropped = 1'b1;
      return;
    end
    pos = store_fill;
    while (pos > 0 && sort_store[pos-1] > v) begin
      sort_store[pos] = sort_store[pos-1];
      pos--;
    end
    sort_store[pos] = v;
    store_fill++;
  endtask

  task automatic predict_item(input logic signed [ValueW-1:0] v, input logic lst);
    out_item_t res;
    sort_insert(v);
    if (lst) begin
      for (int unsigned k = 0; k < store_fill; k++) begin
        res.sorted_value = sort_store[k];
        res.end_of_run   = (k + 1 == store_fill);
        res.overflow     = store_dropped;
        sorted_expect.push_back(res);
      end
      store_fill    = 0;
      store_dropped = 1'b0;
    end
  endtask

  task automatic send_item(input logic signed [ValueW-1:0] v, input logic lst);
    int unsigned gap;
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 3);
      tx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tx_valid <= 1'b1;
    tx_item  <= '{value: v, last: lst};
    do @(posedge clk); while (in_stall);
    predict_item(v, lst);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    tx_valid <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    logic signed [ValueW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6, 7:       v = int'($urandom_range(0, 8)) - 4;
      8: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          default: v = -1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) != 0) begin
          v = 32'sh7FFF_FFFF - $urandom_range(0, 3);
        end else begin
          v = 32'sh8000_0000 + $urandom_range(0, 3);
        end
      end
    endcase
    return v;
  endfunction

  task automatic send_set(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(pick_value(), i + 1 == len);
    end
  endtask

  // receive side: random stall bursts, plus a long hold-off on request
  initial begin
    int unsigned burst;
    int unsigned hold_left;
    burst     = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = hold_len;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        burst = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_expect.size() == 0) begin
        if (err_count < 10) begin
          $display("%0t: unexpected result value=%0d end=%b ovf=%b", $realtime,
                   out_item.sorted_value, out_item.end_of_run, out_item.overflow);
        end
        err_count++;
      end else begin
        want = sorted_expect.pop_front();
        if (out_item.sorted_value !== want.sorted_value ||
            out_item.end_of_run !== want.end_of_run ||
            out_item.overflow !== want.overflow) begin
          if (err_count < 10) begin
            $display("%0t: mismatch exp value=%0d end=%b ovf=%b, got value=%0d end=%b ovf=%b",
                     $realtime, want.sorted_value, want.end_of_run, want.overflow,
                     out_item.sorted_value, out_item.end_of_run, out_item.overflow);
          end
          err_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(-1, 1'b1);
  endtask

  task automatic test_single_item();
    send_item(32'sh1234_5678, 1'b1);
  endtask

  // fill the store, drop one plain item, then drop the last item as well
  task automatic test_overflow();
    for (int i = 0; i < DEPTH; i++) begin
      send_item(DEPTH - i, 1'b0);
    end
    send_item(-5, 1'b0);
    send_item(32'sh8000_0000, 1'b1);
  endtask

  task automatic test_receiver_hold();
    gap_pct  = 0;
    hold_len = 80;
    hold_req = 1'b1;
    send_set(DEPTH);
    send_set(6);
    wait_drained();
    gap_pct = 25;
  endtask

  task automatic test_random_sets();
    int unsigned len;
    int unsigned pct [3] = '{0, 15, 40};
    while (items_sent < 300) begin
      gap_pct   = pct[$urandom_range(0, 2)];
      stall_pct = pct[$urandom_range(0, 2)];
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(1, 6);
        6, 7, 8:          len = $urandom_range(7, DEPTH);
        default:          len = $urandom_range(DEPTH + 1, DEPTH + 4);
      endcase
      send_set(len);
    end
  endtask

  task automatic test_no_idle();
    int unsigned stop_at;
    gap_pct   = 0;
    stall_pct = 0;
    stop_at   = items_sent + 40;
    while (items_sent < stop_at) begin
      send_set($urandom_range(1, DEPTH + 2));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_single_item();
    test_overflow();
    test_receiver_hold();
    test_random_sets();
    test_no_idle();

    wait_drained();
    repeat (DEPTH + 4) @(posedge clk);
    if (err_count == 0 && sorted_expect.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
